>>> src/glu_pkg.sv
// Package: shared widths, defaults and sequencer state type for the GCD/LCM unit.
package glu_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int GCD_WIDTH         = 16;
	localparam int LCM_WIDTH         = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUCLID,
		ST_QUOT,
		ST_MUL,
		ST_FINISH
	} state_t;

endpackage

>>> src/glu_ifs.sv
// Interfaces: operand channel and result channel of the GCD/LCM unit.
interface glu_in_if #(
	parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
);
	logic                     valid;
	logic                     ready;
	logic [OPERAND_WIDTH-1:0] operand_a;
	logic [OPERAND_WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface glu_out_if;
	logic                           valid;
	logic                           ready;
	logic [glu_pkg::GCD_WIDTH-1:0]  gcd_value;
	logic [glu_pkg::LCM_WIDTH-1:0]  lcm_value;
	logic                           zero_error;

	modport source (output valid, output gcd_value, output lcm_value, output zero_error,
		input ready);
	modport sink   (input valid, input gcd_value, input lcm_value, input zero_error,
		output ready);
endinterface

>>> src/gcd_lcm_unit.sv
// Top level: GCD by repeated remainder and LCM as (a / gcd) * b, on one shared adder.
//
//  channel    dir  words / fields
//  -------    ---  ---------------------------------------------------
//  operands   in   operand_a, operand_b  (OPERAND_WIDTH bits each)
//  results    out  gcd_value[15:0], lcm_value[31:0], zero_error
//
// Sequence: a pair with a zero operand goes from IDLE straight to FINISH and the output register.
// Otherwise it runs k remainder steps in EUCLID, then QUOT and MUL; k is the
// number Euclid needs (k <= 23 at 16 bits). Every remainder, the
// quotient a / gcd and the product are worked one bit a cycle through the
// single OPERAND_WIDTH+2 bit add/subtract unit.
// Reset: arst_n clears the sequencer, the bit counter and the output valid.
// Stalls: the result sits in its own register, so a new pair may be taken
// while the last result waits; the unit holds in FINISH only if the output
// register is still full when the next result is ready.
module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	glu_in_if.sink    operands,
	glu_out_if.source results
);
	import glu_pkg::*;

	localparam int W      = OPERAND_WIDTH;
	localparam int CNT_W  = $clog2(W);
	localparam int PROD_W = 2 * W;
	localparam int LCM_XW = (PROD_W > LCM_WIDTH) ? PROD_W : LCM_WIDTH;
	localparam int GCD_XW = (W > GCD_WIDTH) ? W : GCD_WIDTH;

	// sequencer
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic last_bit;
	logic in_accept;
	logic out_load;
	logic out_valid_q;

	// operand and working registers
	logic [W-1:0] a_q, b_q;
	logic [W-1:0] x_q, y_q;     // Euclid pair; x holds gcd, y the multiplicand later
	logic [W-1:0] rem_q, quo_q; // divider remainder / quotient, product high / low
	logic         err_q;

	// shared add/subtract unit
	logic [W:0]   add_x, add_y;
	logic         add_sub;
	logic [W+1:0] add_sum;
	logic [W-1:0] dvsr;
	logic         div_ge;
	logic [W-1:0] rem_n, quo_n;
	logic         mul_mode;

	// result register
	logic [GCD_WIDTH-1:0] gcd_q;
	logic [LCM_WIDTH-1:0] lcm_q;
	logic                 zero_q;
	logic [PROD_W-1:0]    prod;
	logic [LCM_XW-1:0]    prod_x;
	logic [GCD_XW-1:0]    gcd_x;

	assign in_accept = operands.valid && operands.ready;
	assign last_bit  = (cnt_q == CNT_W'(W - 1));
	assign mul_mode  = (state_q == ST_MUL);
	assign dvsr      = (state_q == ST_QUOT) ? x_q : y_q;

	// Divide step: shift one dividend bit into the remainder and trial-subtract.
	// Multiply step: add multiplicand into the high half if the low bit is set,
	// then shift the pair right.
	always_comb begin
		if (mul_mode) begin
			add_x   = {1'b0, rem_q};
			add_y   = quo_q[0] ? {1'b0, y_q} : '0;
			add_sub = 1'b0;
		end else begin
			add_x   = {rem_q, quo_q[W-1]};
			add_y   = {1'b0, dvsr};
			add_sub = 1'b1;
		end
	end

	assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
	assign div_ge  = add_sum[W+1];

	always_comb begin
		if (mul_mode) begin
			rem_n = add_sum[W:1];
			quo_n = {add_sum[0], quo_q[W-1:1]};
		end else begin
			rem_n = div_ge ? add_sum[W-1:0] : add_x[W-1:0];
			quo_n = {quo_q[W-2:0], div_ge};
		end
	end

	// next state and handshake
	always_comb begin
		state_d        = state_q;
		operands.ready = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				operands.ready = 1'b1;
				if (operands.valid) begin
					if (operands.operand_a == '0 || operands.operand_b == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_EUCLID;
					end
				end
			end
			ST_EUCLID: begin
				if (last_bit && rem_n == '0) begin
					state_d = ST_QUOT;
				end
			end
			ST_QUOT: begin
				if (last_bit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (last_bit) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				out_load = !out_valid_q || results.ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EUCLID || state_q == ST_QUOT || state_q == ST_MUL) begin
				cnt_q <= last_bit ? '0 : cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					a_q   <= operands.operand_a;
					b_q   <= operands.operand_b;
					x_q   <= operands.operand_a;
					y_q   <= operands.operand_b;
					quo_q <= operands.operand_a;
					rem_q <= '0;
					err_q <= (operands.operand_a == '0) || (operands.operand_b == '0);
				end
			end
			ST_EUCLID: begin
				if (last_bit) begin
					x_q   <= y_q;
					y_q   <= rem_n;
					rem_q <= '0;
					// remainder zero: y is the gcd, go on to a / gcd
					quo_q <= (rem_n == '0) ? a_q : y_q;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
				end
			end
			ST_QUOT: begin
				if (last_bit) begin
					y_q   <= quo_n;
					quo_q <= b_q;
					rem_q <= '0;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
				end
			end
			ST_MUL: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			ST_FINISH: begin
				if (out_load) begin
					gcd_q  <= err_q ? '0 : gcd_x[GCD_WIDTH-1:0];
					lcm_q  <= err_q ? '0 : prod_x[LCM_WIDTH-1:0];
					zero_q <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign prod   = {rem_q, quo_q};
	assign prod_x = LCM_XW'(prod);
	assign gcd_x  = GCD_XW'(x_q);

	assign results.valid      = out_valid_q;
	assign results.gcd_value  = gcd_q;
	assign results.lcm_value  = lcm_q;
	assign results.zero_error = zero_q;

	// never divide by zero
	a_euclid_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EUCLID |-> y_q != '0)
		else $error("Euclid step with zero divisor");

	a_quot_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUOT |-> x_q != '0)
		else $error("a / gcd with zero gcd");

	// the first division of a newly taken pair starts on bit zero
	a_cnt_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> cnt_q == '0)
		else $error("bit counter not cleared at start");

	// error words carry zero values
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.zero_error |-> results.gcd_value == '0 &&
			results.lcm_value == '0)
		else $error("zero operand word with nonzero fields");

	// a good pair reaches FINISH with a nonzero gcd
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && !err_q |-> x_q != '0)
		else $error("zero gcd without error");

endmodule
